// ----- rtl/kthsj_pkg.sv -----
`timescale 1ns / 1ps
package kthsj_pkg;

	// fixed field widths
	localparam int NODE_W  = 10;
	localparam int STEPS_W = 30;
	localparam int COUNT_W = 11;

	localparam logic [COUNT_W-1:0] COUNT_RESET = 11'd1024;

	// parameter defaults
	localparam int NODE_BITS_DEF = 10;
	localparam int LEVELS_DEF    = 30;

	// action codes
	localparam logic ACT_LOAD  = 1'b0;
	localparam logic ACT_QUERY = 1'b1;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_RB_A,
		ST_RB_B,
		ST_RB_C,
		ST_CHECK,
		ST_WALK,
		ST_DONE
	} state_t;

	typedef struct packed {
		logic load_wr;      // write level 0 from the input request
		logic capture;      // latch query node and steps
		logic rb_init;      // start rebuild at level 1, node 0
		logic rb_rd_a;      // read lower level at v
		logic rb_rd_b;      // read lower level at mid
		logic rb_write;     // write level at v, advance
		logic clear_stale;
		logic walk_init;
		logic walk_step;
		logic walk_finish;
		logic res_load;
	} cmd_t;

	typedef struct packed {
		logic stale;
		logic rb_empty;     // nothing to rebuild
		logic v_last;
		logic lvl_last;
		logic walk_done;
		logic bad;
		logic out_free;
	} status_t;

endpackage

// ----- rtl/kthsj_ctrl.sv -----
`timescale 1ns / 1ps
module kthsj_ctrl
	import kthsj_pkg::*;
(
	input  logic    clk,
	input  logic    arst_n,
	input  logic    in_valid,
	input  logic    action,
	output logic    in_stall,
	input  status_t sts,
	output cmd_t    cmd
);

	state_t state_q;
	state_t state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (in_valid && action == ACT_QUERY) begin
					state_d = (sts.stale && !sts.rb_empty) ? ST_RB_A : ST_CHECK;
				end
			end
			ST_RB_A: state_d = ST_RB_B;
			ST_RB_B: state_d = ST_RB_C;
			ST_RB_C: state_d = (sts.v_last && sts.lvl_last) ? ST_CHECK : ST_RB_A;
			ST_CHECK: state_d = sts.bad ? ST_DONE : ST_WALK;
			ST_WALK: begin
				if (sts.walk_done) begin
					state_d = ST_DONE;
				end
			end
			ST_DONE: begin
				if (sts.out_free) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		cmd = '0;
		case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					if (action == ACT_LOAD) begin
						cmd.load_wr = 1'b1;
					end else begin
						cmd.capture = 1'b1;
						if (sts.stale) begin
							if (sts.rb_empty) begin
								cmd.clear_stale = 1'b1;
							end else begin
								cmd.rb_init = 1'b1;
							end
						end
					end
				end
			end
			ST_RB_A: cmd.rb_rd_a = 1'b1;
			ST_RB_B: cmd.rb_rd_b = 1'b1;
			ST_RB_C: begin
				cmd.rb_write    = 1'b1;
				cmd.clear_stale = sts.v_last && sts.lvl_last;
			end
			ST_CHECK: cmd.walk_init = 1'b1;
			ST_WALK: begin
				if (sts.walk_done) begin
					cmd.walk_finish = 1'b1;
				end else begin
					cmd.walk_step = 1'b1;
				end
			end
			ST_DONE: cmd.res_load = sts.out_free;
			default: cmd = '0;
		endcase
	end

	assign in_stall = (state_q != ST_IDLE);

	// walks only ever see a rebuilt table
	a_walk_fresh: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_WALK || state_q == ST_CHECK) |-> !sts.stale)
		else $error("walk on stale table");

	a_res_free: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.res_load |-> sts.out_free)
		else $error("result overwrites pending output");

	a_rb_order: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_RB_C) |-> ($past(state_q) == ST_RB_B))
		else $error("rebuild write without mid read");

endmodule

// ----- rtl/kthsj_datapath.sv -----
`timescale 1ns / 1ps
module kthsj_datapath
	import kthsj_pkg::*;
#(
	parameter int NODE_BITS = NODE_BITS_DEF,
	parameter int LEVELS    = LEVELS_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_we,
	input  logic [COUNT_W-1:0] cfg_wdata,
	input  logic [NODE_W-1:0]  node,
	input  logic [NODE_W-1:0]  target,
	input  logic [STEPS_W-1:0] steps,
	input  cmd_t               cmd,
	output status_t            sts,
	input  logic               out_stall,
	output logic               out_valid,
	output logic [NODE_W-1:0]  destination,
	output logic               bad_node
);

	localparam int NODE_SPAN   = 1 << NODE_BITS;
	localparam int DEPTH       = LEVELS * NODE_SPAN;
	localparam int ADDR_W      = $clog2(DEPTH);
	localparam int LIDX_W      = (LEVELS > 1) ? $clog2(LEVELS) : 1;
	localparam int LVL_W       = $clog2(LEVELS + 1);
	localparam int CNT_W       = (NODE_BITS + 1 > COUNT_W) ? NODE_BITS + 1 : COUNT_W;
	localparam int WALK_LEVELS = (LEVELS < STEPS_W) ? LEVELS : STEPS_W;

	logic [COUNT_W-1:0]   node_count_q;
	logic                 stale_q;
	logic [NODE_W-1:0]    node_q;
	logic [STEPS_W-1:0]   steps_q;
	logic [LVL_W-1:0]     lvl_q;
	logic [NODE_BITS-1:0] v_q;
	logic [NODE_BITS-1:0] cur_q;
	logic                 pending_q;
	logic [NODE_BITS-1:0] rd_data_q;
	logic                 out_valid_q;
	logic [NODE_W-1:0]    destination_q;
	logic                 bad_node_q;

	logic [NODE_BITS-1:0] table_q [DEPTH];

	logic [CNT_W-1:0]     count_ext;
	logic [CNT_W-1:0]     cnt_eff;
	logic [CNT_W-1:0]     cnt_last;
	logic [LIDX_W-1:0]    lvl_idx;
	logic [LIDX_W-1:0]    prev_idx;
	logic [NODE_BITS-1:0] cur_eff;
	logic                 rd_en;
	logic [ADDR_W-1:0]    rd_addr;
	logic                 wr_en;
	logic [ADDR_W-1:0]    wr_addr;
	logic [NODE_BITS-1:0] wr_data;

	function automatic logic [ADDR_W-1:0] mk_addr(input logic [LIDX_W-1:0] lv,
		input logic [NODE_BITS-1:0] nd);
		return ADDR_W'({lv, nd});
	endfunction

	// count limited to the table span
	assign count_ext = CNT_W'(node_count_q);
	assign cnt_eff   = (count_ext > CNT_W'(NODE_SPAN)) ? CNT_W'(NODE_SPAN) : count_ext;
	assign cnt_last  = cnt_eff - 1'b1;

	assign lvl_idx  = lvl_q[LIDX_W-1:0];
	assign prev_idx = LIDX_W'(lvl_q - 1'b1);
	assign cur_eff  = pending_q ? rd_data_q : cur_q;

	always_comb begin
		rd_en = cmd.rb_rd_a || cmd.rb_rd_b || (cmd.walk_step && steps_q[0]);
		if (cmd.rb_rd_a) begin
			rd_addr = mk_addr(prev_idx, v_q);
		end else if (cmd.rb_rd_b) begin
			rd_addr = mk_addr(prev_idx, rd_data_q);
		end else begin
			rd_addr = mk_addr(lvl_idx, cur_eff);
		end
	end

	always_comb begin
		wr_en = cmd.load_wr || cmd.rb_write;
		if (cmd.load_wr) begin
			wr_addr = mk_addr('0, NODE_BITS'(node));
			wr_data = NODE_BITS'(target);
		end else begin
			wr_addr = mk_addr(lvl_idx, v_q);
			wr_data = rd_data_q;
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			table_q[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data_q <= table_q[rd_addr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			node_count_q <= COUNT_RESET;
			stale_q      <= 1'b1;
			lvl_q        <= '0;
			v_q          <= '0;
			pending_q    <= 1'b0;
			out_valid_q  <= 1'b0;
		end else begin
			if (cfg_we) begin
				node_count_q <= cfg_wdata;
			end

			if (cfg_we || cmd.load_wr) begin
				stale_q <= 1'b1;
			end else if (cmd.clear_stale) begin
				stale_q <= 1'b0;
			end

			if (cmd.rb_init) begin
				lvl_q <= LVL_W'(1);
				v_q   <= '0;
			end else if (cmd.rb_write) begin
				if (sts.v_last) begin
					v_q   <= '0;
					lvl_q <= lvl_q + 1'b1;
				end else begin
					v_q <= v_q + 1'b1;
				end
			end else if (cmd.walk_init) begin
				lvl_q <= '0;
			end else if (cmd.walk_step) begin
				lvl_q <= lvl_q + 1'b1;
			end

			if (cmd.walk_init || cmd.walk_finish) begin
				pending_q <= 1'b0;
			end else if (cmd.walk_step) begin
				pending_q <= steps_q[0];
			end

			if (cmd.res_load) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			node_q  <= node;
			steps_q <= steps;
		end else if (cmd.walk_step) begin
			steps_q <= steps_q >> 1;
		end

		if (cmd.walk_init) begin
			cur_q <= NODE_BITS'(node_q);
		end else if (cmd.walk_step || cmd.walk_finish) begin
			cur_q <= cur_eff;
		end

		if (cmd.res_load) begin
			destination_q <= sts.bad ? '0 : NODE_W'(cur_q);
			bad_node_q    <= sts.bad;
		end
	end

	always_comb begin
		sts.stale     = stale_q;
		sts.rb_empty  = (cnt_eff == '0) || (LEVELS == 1);
		sts.v_last    = (CNT_W'(v_q) == cnt_last);
		sts.lvl_last  = (lvl_q == LVL_W'(LEVELS - 1));
		sts.walk_done = (lvl_q == LVL_W'(WALK_LEVELS));
		sts.bad       = (CNT_W'(node_q) >= cnt_eff);
		sts.out_free  = !out_valid_q || !out_stall;
	end

	assign out_valid   = out_valid_q;
	assign destination = destination_q;
	assign bad_node    = bad_node_q;

	// mid read must use the data of the read just before it
	a_mid_read: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.rb_rd_b |-> $past(cmd.rb_rd_a))
		else $error("mid read without first read");

	a_rb_level: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.rb_write |-> (lvl_q != '0 && lvl_q < LVL_W'(LEVELS)))
		else $error("rebuild write outside levels");

	a_one_writer: assert property (@(posedge clk) disable iff (!arst_n)
		!(cmd.load_wr && cmd.rb_write))
		else $error("two table writers");

endmodule

// ----- rtl/kth_successor_jump_table_core.sv -----
`timescale 1ns / 1ps
// Load request: no result; loads can follow back to back.
// Query, table fresh: range check, then min(LEVELS,30) walk steps before the result loads;
//   next request taken the cycle after the result loads.
// First query after a load or count write first rebuilds every level above 0 for each live node.
// Bad start node: no walk, result after the check. One request in flight at a time.
// Reset: control cleared, node_count = 1024, table stale; contents undefined until loaded.
module kth_successor_jump_table_core
	import kthsj_pkg::*;
#(
	parameter int NODE_BITS = NODE_BITS_DEF,
	parameter int LEVELS    = LEVELS_DEF
) (
	input  logic               clk,
	input  logic               arst_n,

	input  logic               cfg_we,
	input  logic [COUNT_W-1:0] cfg_wdata,

	input  logic               in_valid,
	output logic               in_stall,
	input  logic               action,
	input  logic [NODE_W-1:0]  node,
	input  logic [NODE_W-1:0]  target,
	input  logic [STEPS_W-1:0] steps,

	output logic               out_valid,
	input  logic               out_stall,
	output logic [NODE_W-1:0]  destination,
	output logic               bad_node
);

	// Controller sequences each request:
	//   load  - level 0 written straight from the input port
	//   query - optional rebuild (per entry: read v, read mid, write),
	//           range check, then one walk step per step bit; a set bit issues a
	//           table read whose data feeds the next read address directly.
	// The table is one single-port-read, single-port-write RAM of
	// LEVELS x 2^NODE_BITS entries; that read port sets the pace.
	// Result sits in an output register so the walk can finish while
	// the consumer stalls.

	cmd_t    cmd;
	status_t sts;

	kthsj_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.action   (action),
		.in_stall (in_stall),
		.sts      (sts),
		.cmd      (cmd)
	);

	kthsj_datapath #(
		.NODE_BITS (NODE_BITS),
		.LEVELS    (LEVELS)
	) u_datapath (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_we      (cfg_we),
		.cfg_wdata   (cfg_wdata),
		.node        (node),
		.target      (target),
		.steps       (steps),
		.cmd         (cmd),
		.sts         (sts),
		.out_stall   (out_stall),
		.out_valid   (out_valid),
		.destination (destination),
		.bad_node    (bad_node)
	);

endmodule

// ----- test/kth_successor_jump_table_core_tb.sv -----
`timescale 1ns / 1ps
module kth_successor_jump_table_core_tb;
	import kthsj_pkg::*;

	localparam int LVLS        = LEVELS_DEF;
	localparam int SPAN        = 1 << NODE_BITS_DEF;
	localparam int PHASE_ITEMS = 120;      // random requests per idling phase
	localparam int QUIET_LIMIT = 500000;   // watchdog limit, above a full 1024-node rebuild
	localparam int SETTLE      = 40;
	localparam logic [STEPS_W-1:0] STEPS_ALL = '1;

	typedef enum logic [1:0] {
		ROW_CFG,
		ROW_LOAD,
		ROW_QUERY
	} row_kind_t;

	typedef struct packed {
		logic [NODE_W-1:0] dest;
		logic              bad;
	} answer_t;

	// one line of the directed script; want is used only when typed is set
	typedef struct {
		row_kind_t          kind;
		logic [NODE_W-1:0]  node;
		logic [NODE_W-1:0]  target;
		logic [STEPS_W-1:0] steps;
		logic [COUNT_W-1:0] count;
		bit                 typed;
		answer_t            want;
	} row_t;

	logic               clk       = 1'b0;
	logic               arst_n    = 1'b0;
	logic               cfg_we    = 1'b0;
	logic [COUNT_W-1:0] cfg_wdata = '0;
	logic               in_valid  = 1'b0;
	logic               in_stall;
	logic               action    = ACT_LOAD;
	logic [NODE_W-1:0]  node      = '0;
	logic [NODE_W-1:0]  target    = '0;
	logic [STEPS_W-1:0] steps     = '0;
	logic               out_valid;
	logic               out_stall = 1'b0;
	logic [NODE_W-1:0]  destination;
	logic               bad_node;

	kth_successor_jump_table_core dut (.*);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	// ---------------------------------------------------------------
	// Predictor state: our own copy of the doubling table, the node
	// count register and the stale flag. lift[i][v] is the 2^i-th
	// successor of v.
	// ---------------------------------------------------------------
	logic [NODE_W-1:0]  lift [LVLS][SPAN];
	logic [COUNT_W-1:0] model_count = COUNT_RESET;
	bit                 lift_stale  = 1'b1;

	answer_t     pending_answers [$];   // expected results, oldest first
	row_t        script [$];
	int unsigned send_idle_pct = 0;
	int unsigned stall_pct     = 0;
	int unsigned sent          = 0;
	int unsigned fail_count    = 0;
	int unsigned quiet_cycles  = 0;

	function automatic void queue_answer(input answer_t a);
		pending_answers.insert(pending_answers.size(), a);
	endfunction

	function automatic void add_row(input row_t r);
		script.insert(script.size(), r);
	endfunction

	// counts above the table size clamp to the table
	function automatic int unsigned live_nodes();
		return (model_count > SPAN) ? SPAN : model_count;
	endfunction

	// Walk a query: rebuild first if anything changed since the last one
	// (even when the start node turns out bad), then take one jump per
	// set step bit. Bits at or above LEVELS do not exist in the port.
	function automatic answer_t resolve_query(input logic [NODE_W-1:0] start,
			input logic [STEPS_W-1:0] hops);
		answer_t           a;
		int unsigned       n;
		logic [NODE_W-1:0] cur;
		n = live_nodes();
		if (lift_stale) begin
			for (int lv = 1; lv < LVLS; lv++)
				for (int v = 0; v < n; v++)
					lift[lv][v] = lift[lv-1][lift[lv-1][v]];
			lift_stale = 1'b0;
		end
		if (start >= n) begin
			a.dest = '0;
			a.bad  = 1'b1;
			return a;
		end
		cur = start;
		for (int b = 0; b < LVLS; b++)
			if (hops[b])
				cur = lift[b][cur];
		a.dest = cur;
		a.bad  = 1'b0;
		return a;
	endfunction

	// Present one request, with random sender gaps ahead of it, and hold
	// it until accepted. in_stall is sampled at the falling edge, where it
	// is settled for the next rising edge. Returns on the accepting edge.
	task automatic push_request(input logic act, input logic [NODE_W-1:0] nd,
			input logic [NODE_W-1:0] tg, input logic [STEPS_W-1:0] st,
			input bit typed, input answer_t want);
		answer_t got;
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		action   <= act;
		node     <= nd;
		target   <= tg;
		steps    <= st;
		@(negedge clk);
		while (in_stall)
			@(negedge clk);
		@(posedge clk);
		if (act == ACT_LOAD) begin
			lift[0][nd] = tg;
			lift_stale  = 1'b1;
		end else begin
			got = resolve_query(nd, st);
			queue_answer(typed ? want : got);
		end
		sent++;
	endtask

	task automatic load_node(input logic [NODE_W-1:0] nd, input logic [NODE_W-1:0] tg);
		push_request(ACT_LOAD, nd, tg, '0, 1'b0, '0);
	endtask

	task automatic query_node(input logic [NODE_W-1:0] nd, input logic [STEPS_W-1:0] st);
		push_request(ACT_QUERY, nd, '0, st, 1'b0, '0);
	endtask

	// Count writes only land on an idle block: stop sending, let every
	// pending result drain, let a trailing load settle, then write.
	task automatic set_node_count(input logic [COUNT_W-1:0] n);
		in_valid <= 1'b0;
		while (pending_answers.size() != 0)
			@(posedge clk);
		repeat (8) @(posedge clk);
		cfg_we    <= 1'b1;
		cfg_wdata <= n;
		@(posedge clk);
		cfg_we      <= 1'b0;
		model_count = n;
		lift_stale  = 1'b1;
	endtask

	// mostly a node inside the live range, sometimes anywhere in the table
	function automatic logic [NODE_W-1:0] pick_node(input int unsigned n,
			input int unsigned inside_pct);
		if (n == 0 || $urandom_range(99) >= inside_pct)
			return NODE_W'($urandom_range(SPAN - 1));
		return NODE_W'($urandom_range(n - 1));
	endfunction

	function automatic logic [STEPS_W-1:0] pick_steps();
		case ($urandom_range(3))
			0, 1: return STEPS_W'($urandom_range(STEPS_ALL));
			2: return STEPS_W'($urandom_range(64));
			default: return STEPS_W'(1) << $urandom_range(STEPS_W - 1);
		endcase
	endfunction

	function automatic row_t mk_row(input row_kind_t k, input int unsigned nd,
			input int unsigned tg, input int unsigned st, input int unsigned cnt,
			input int unsigned typed, input int unsigned dst, input int unsigned bad);
		row_t r;
		r.kind      = k;
		r.node      = NODE_W'(nd);
		r.target    = NODE_W'(tg);
		r.steps     = STEPS_W'(st);
		r.count     = COUNT_W'(cnt);
		r.typed     = 1'(typed);
		r.want.dest = NODE_W'(dst);
		r.want.bad  = 1'(bad);
		return r;
	endfunction

	// ---------------------------------------------------------------
	// Result side: random stall, checked at the falling edge so the
	// values seen are the ones taken at the next rising edge.
	// ---------------------------------------------------------------
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_stall <= 1'b0;
		else
			out_stall <= ($urandom_range(99) < stall_pct);
	end

	always @(negedge clk) begin : result_check
		answer_t w;
		if (arst_n && out_valid && !out_stall) begin
			if (pending_answers.size() == 0) begin
				$error("result with nothing pending: destination %0d bad_node %0d",
					destination, bad_node);
				fail_count++;
			end else begin
				w = pending_answers.pop_front();
				if (destination !== w.dest) begin
					$error("destination: expected %0d, got %0d", w.dest, destination);
					fail_count++;
				end
				if (bad_node !== w.bad) begin
					$error("bad_node: expected %0d, got %0d", w.bad, bad_node);
					fail_count++;
				end
			end
		end
	end

	// watchdog: too long with no request and no result taken
	always @(negedge clk) begin
		if (!arst_n || (in_valid && !in_stall) || (out_valid && !out_stall))
			quiet_cycles = 0;
		else
			quiet_cycles++;
		if (quiet_cycles >= QUIET_LIMIT) begin
			$display("Test completed with failures");
			$finish;
		end
	end

	// ---------------------------------------------------------------
	// Stimulus
	// ---------------------------------------------------------------
	initial begin
		int unsigned n;
		int unsigned r;

		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);

		// Fill: the table powers up undefined, so every level-0 entry is
		// loaded and one query at the reset count builds all levels for
		// all nodes. After this no read can hit a never-written entry.
		for (int v = 0; v < SPAN; v++)
			load_node(v[NODE_W-1:0], NODE_W'($urandom_range(SPAN - 1)));
		query_node(NODE_W'($urandom_range(SPAN - 1)), STEPS_W'($urandom_range(STEPS_ALL)));

		// Directed script. Typed answers only where obvious.
		// zero node count: everything is flagged, field extremes included
		add_row(mk_row(ROW_CFG,   0,    0, 0,          0,    0, 0,    0));
		add_row(mk_row(ROW_QUERY, 0,    0, 1,          0,    1, 0,    1));
		add_row(mk_row(ROW_QUERY, 1023, 0, 'h3FFFFFFF, 0,    1, 0,    1));
		// 4-node ring 0->1->2->3->0
		add_row(mk_row(ROW_CFG,   0,    0, 0,          4,    0, 0,    0));
		add_row(mk_row(ROW_LOAD,  0,    1, 0,          0,    0, 0,    0));
		add_row(mk_row(ROW_LOAD,  1,    2, 0,          0,    0, 0,    0));
		add_row(mk_row(ROW_LOAD,  2,    3, 0,          0,    0, 0,    0));
		add_row(mk_row(ROW_LOAD,  3,    0, 0,          0,    0, 0,    0));
		add_row(mk_row(ROW_QUERY, 0,    0, 0,          0,    1, 0,    0));
		add_row(mk_row(ROW_QUERY, 1,    0, 1,          0,    1, 2,    0));
		add_row(mk_row(ROW_QUERY, 3,    0, 'h3FFFFFFF, 0,    0, 0,    0));
		add_row(mk_row(ROW_QUERY, 2,    0, 'h20000000, 0,    0, 0,    0));
		// start node equal to the count
		add_row(mk_row(ROW_QUERY, 4,    0, 7,          0,    1, 0,    1));
		// successor outside the count: walk runs through stale upper levels
		add_row(mk_row(ROW_LOAD,  3, 1000, 0,          0,    0, 0,    0));
		add_row(mk_row(ROW_QUERY, 2,    0, 3,          0,    0, 0,    0));
		add_row(mk_row(ROW_QUERY, 1,    0, 'h20000001, 0,    0, 0,    0));
		// single node pointing at itself
		add_row(mk_row(ROW_CFG,   0,    0, 0,          1,    0, 0,    0));
		add_row(mk_row(ROW_LOAD,  0,    0, 0,          0,    0, 0,    0));
		add_row(mk_row(ROW_QUERY, 0,    0, 'h3FFFFFFF, 0,    1, 0,    0));
		add_row(mk_row(ROW_QUERY, 1,    0, 0,          0,    1, 0,    1));
		// count beyond the table clamps to 1024; top node self-loop
		add_row(mk_row(ROW_LOAD,  1023, 1023, 0,       0,    0, 0,    0));
		add_row(mk_row(ROW_CFG,   0,    0, 0,          2047, 0, 0,    0));
		add_row(mk_row(ROW_QUERY, 1023, 0, 0,          0,    1, 1023, 0));
		add_row(mk_row(ROW_QUERY, 1023, 0, 'h3FFFFFFF, 0,    1, 1023, 0));

		foreach (script[i]) begin
			case (script[i].kind)
				ROW_CFG: set_node_count(script[i].count);
				ROW_LOAD: push_request(ACT_LOAD, script[i].node, script[i].target,
					script[i].steps, 1'b0, '0);
				default: push_request(ACT_QUERY, script[i].node, script[i].target,
					script[i].steps, script[i].typed, script[i].want);
			endcase
		end

		// Random part: each count setting gets a few load bursts, each
		// followed by a query burst, so most queries hit a fresh table and
		// rebuilds stay rare. Counts are kept small to bound rebuild time.
		sent = 0;
		for (int ph = 0; ph < 4; ph++) begin
			case (ph)
				0: begin
					send_idle_pct = 0;
					stall_pct     = 0;
				end
				1: begin
					send_idle_pct = 87;
					stall_pct     = 0;
				end
				2: begin
					send_idle_pct = 0;
					stall_pct     = 87;
				end
				default: begin
					send_idle_pct = 38;
					stall_pct     = 38;
				end
			endcase
			while (sent < (ph + 1) * PHASE_ITEMS) begin
				r = $urandom_range(99);
				if (r < 5)
					set_node_count('0);
				else if (r < 15)
					set_node_count(COUNT_W'($urandom_range(250, 33)));
				else
					set_node_count(COUNT_W'($urandom_range(32, 1)));
				n = live_nodes();
				repeat ($urandom_range(5, 2)) begin
					repeat ($urandom_range(4, 0))
						load_node(pick_node(n, 80), pick_node(n, 85));
					repeat ($urandom_range(12, 3))
						query_node(pick_node(n, 85), pick_steps());
				end
			end
		end

		in_valid <= 1'b0;
		while (pending_answers.size() != 0)
			@(posedge clk);
		repeat (SETTLE) @(posedge clk);
		if (fail_count == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end

endmodule

// ----- kth_successor_jump_table_core.f -----
rtl/kthsj_pkg.sv
rtl/kthsj_ctrl.sv
rtl/kthsj_datapath.sv
rtl/kth_successor_jump_table_core.sv
test/kth_successor_jump_table_core_tb.sv
